>>> design/sba_pkg.sv
// Shared types and constants of the stream block allocator.
// Item layouts, request and status codes, store geometry.
// No dependencies.
package sba_pkg;

    localparam int STREAM_SLOTS = 16;
    localparam int LIST_BLOCKS  = 64;
    localparam int STORE_BLOCKS = 1024;
    localparam int POS_W        = $clog2(LIST_BLOCKS);
    localparam int BLK_W        = $clog2(STORE_BLOCKS);

    localparam logic [22:0] SIZE_LIMIT = 23'd4194304;
    localparam int          HDR_FIXED  = 22;
    localparam int          HDR_START  = 26;
    localparam int          HDR_TAIL   = 4;
    localparam logic [16:0] BS_RESET   = 17'd512;
    localparam logic [16:0] BS_MAX     = 17'd65536;
    localparam logic signed [15:0] ID_MAX = 16'sd32767;

    localparam logic [2:0] REQ_FORMAT      = 3'd0;
    localparam logic [2:0] REQ_CREATE_AUTO = 3'd1;
    localparam logic [2:0] REQ_CREATE_ID   = 3'd2;
    localparam logic [2:0] REQ_DELETE      = 3'd3;
    localparam logic [2:0] REQ_SET_SIZE    = 3'd4;
    localparam logic [2:0] REQ_LOOKUP      = 3'd5;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_INVALID_ID  = 3'd1;
    localparam logic [2:0] ST_PROTECTED   = 3'd2;
    localparam logic [2:0] ST_EXISTS      = 3'd3;
    localparam logic [2:0] ST_NO_STREAM   = 3'd4;
    localparam logic [2:0] ST_STORE_FULL  = 3'd5;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd6;
    localparam logic [2:0] ST_LIST_FULL   = 3'd7;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [15:0] stream_id;
        logic [9:0]         count;
        logic [22:0]        new_size;
        logic [5:0]         block_pos;
    } sba_req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [15:0] result_id;
        logic [9:0]         block_index;
        logic [22:0]        stream_size;
        logic [6:0]         stream_blocks;
        logic [10:0]        used_blocks;
        logic [10:0]        total_blocks;
    } sba_rsp_t;

endpackage

>>> design/sba_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the block lists and the free block queue. No package use.
module sba_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/stream_block_allocator.sv
// Stream block allocator top level: request sequencer, stream slot table,
// block list RAM and free block queue RAM (sba_ram). Uses sba_pkg.
//
// One request is worked at a time; a new request is taken while the previous
// response still waits on rsp_stall. The work differs per request: a stream
// id search visits one slot per cycle, block allocation and release move one
// block per cycle through the block list and free queue RAMs, and block counts
// for set size are found by repeated adds of the block size. Format runs the
// header-size search and then writes one block number per cycle, header plus
// count blocks. The RAMs need no clearing pass after reset.
module stream_block_allocator #(
    parameter int MAX_STREAMS = sba_pkg::STREAM_SLOTS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  sba_pkg::sba_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output sba_pkg::sba_rsp_t rsp,
    input  logic              cfg_wen,
    input  logic [16:0]       cfg_wdata
);
    import sba_pkg::*;

    localparam int SLOT_W     = $clog2(MAX_STREAMS);
    localparam int LADDR_W    = SLOT_W + POS_W;
    localparam int LIST_DEPTH = MAX_STREAMS * LIST_BLOCKS;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_STREAMS - 1);
    localparam logic [6:0] LIST_MAX = 7'(LIST_BLOCKS);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_HDR      = 12'b000000000010,
        S_FMT_FILL = 12'b000000000100,
        S_FIND     = 12'b000000001000,
        S_ALLOC    = 12'b000000010000,
        S_FILL     = 12'b000000100000,
        S_FREE     = 12'b000001000000,
        S_HIGH     = 12'b000010000000,
        S_GROW     = 12'b000100000000,
        S_SHRINK   = 12'b001000000000,
        S_LOOK     = 12'b010000000000,
        S_DONE     = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [MAX_STREAMS-1:0] valid_reg, valid_next;
    logic [16:0]            bs_reg, bs_next;
    logic [BLK_W-1:0]       head_reg, head_next;
    logic [BLK_W-1:0]       tail_reg, tail_next;
    logic [10:0]            fcnt_reg, fcnt_next;
    logic [10:0]            total_reg, total_next;
    logic [10:0]            owned_reg, owned_next;
    logic signed [15:0]     highest_reg, highest_next;

    sba_req_t               rq_reg, rq_next;
    logic [2:0]             st_reg, st_next;
    logic signed [15:0]     rid_reg, rid_next;
    logic [9:0]             bidx_reg, bidx_next;
    logic                   has_reg, has_next;

    logic [6:0]             k_reg, k_next;
    logic [22:0]            acc_reg, acc_next;
    logic [8:0]             hs_reg, hs_next;

    logic [6:0]             fj_reg, fj_next;
    logic [6:0]             fend_reg, fend_next;
    logic                   pend_reg, pend_next;
    logic                   pend_fifo_reg, pend_fifo_next;
    logic [9:0]             pend_val_reg, pend_val_next;
    logic [POS_W-1:0]       pend_pos_reg, pend_pos_next;

    logic [6:0]             fi_reg, fi_next;
    logic [6:0]             fn_reg, fn_next;
    logic [6:0]             ccnt_reg, ccnt_next;
    logic                   gpend_reg, gpend_next;

    logic                   any_reg, any_next;
    logic signed [15:0]     hmax_reg, hmax_next;
    logic [10:0]            fmt_j_reg, fmt_j_next;

    logic                   rsp_valid_reg, rsp_valid_next;
    sba_rsp_t               rsp_reg, rsp_next;

    // slot table, read only at slot_reg
    logic signed [15:0]     slot_id_reg   [MAX_STREAMS];
    logic [22:0]            slot_size_reg [MAX_STREAMS];
    logic [6:0]             slot_cnt_reg  [MAX_STREAMS];

    logic [SLOT_W-1:0]      sw_sel;
    logic                   sw_id_we, sw_size_we, sw_cnt_we;
    logic signed [15:0]     sw_id;
    logic [22:0]            sw_size;
    logic [6:0]             sw_cnt;

    logic                   list_we;
    logic [LADDR_W-1:0]     list_waddr, list_raddr;
    logic [BLK_W-1:0]       list_wdata, list_rdata;
    logic                   fifo_we;
    logic [BLK_W-1:0]       fifo_waddr, fifo_raddr, fifo_wdata, fifo_rdata;
    logic                   fifo_take;

    logic [16:0]            bs_eff;
    logic [11:0]            avail;
    logic signed [15:0]     cur_id;
    logic [22:0]            cur_size;
    logic [6:0]             cur_cnt;
    logic                   hit;
    logic                   free_any;
    logic [SLOT_W-1:0]      free_idx;
    logic [8:0]             new_hs;
    logic [6:0]             free_pos;
    logic [10:0]            fmt_off;
    logic                   hi_take;

    assign bs_eff = (bs_reg == 17'd0) ? 17'd1 : ((bs_reg > BS_MAX) ? BS_MAX : bs_reg);
    assign avail  = {1'b0, fcnt_reg} + (12'(STORE_BLOCKS) - {1'b0, total_reg});
    assign cur_id   = slot_id_reg[slot_reg];
    assign cur_size = slot_size_reg[slot_reg];
    assign cur_cnt  = slot_cnt_reg[slot_reg];
    assign hit      = valid_reg[slot_reg] && (cur_id == rq_reg.stream_id);
    assign free_any = ~&valid_reg;
    assign new_hs   = 9'(HDR_FIXED) + {k_reg, 2'b00};
    assign free_pos = (rq_reg.req_type == REQ_DELETE) ? fi_reg : (ccnt_reg - 7'd1 - fi_reg);
    assign fmt_off  = fmt_j_reg - {4'b0000, k_reg};
    assign hi_take  = valid_reg[slot_reg] && (!any_reg || (cur_id > hmax_reg));

    always_comb
    begin
        free_idx = '0;
        for (int i = MAX_STREAMS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        valid_next     = valid_reg;
        bs_next        = cfg_wen ? cfg_wdata : bs_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fcnt_next      = fcnt_reg;
        total_next     = total_reg;
        owned_next     = owned_reg;
        highest_next   = highest_reg;
        rq_next        = rq_reg;
        st_next        = st_reg;
        rid_next       = rid_reg;
        bidx_next      = bidx_reg;
        has_next       = has_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        hs_next        = hs_reg;
        fj_next        = fj_reg;
        fend_next      = fend_reg;
        pend_next      = pend_reg;
        pend_fifo_next = pend_fifo_reg;
        pend_val_next  = pend_val_reg;
        pend_pos_next  = pend_pos_reg;
        fi_next        = fi_reg;
        fn_next        = fn_reg;
        ccnt_next      = ccnt_reg;
        gpend_next     = gpend_reg;
        any_next       = any_reg;
        hmax_next      = hmax_reg;
        fmt_j_next     = fmt_j_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        sw_sel     = slot_reg;
        sw_id_we   = 1'b0;
        sw_size_we = 1'b0;
        sw_cnt_we  = 1'b0;
        sw_id      = rid_reg;
        sw_size    = rq_reg.new_size;
        sw_cnt     = k_reg;

        list_we    = 1'b0;
        list_waddr = {slot_reg, pend_pos_reg};
        list_wdata = pend_fifo_reg ? fifo_rdata : pend_val_reg;
        list_raddr = {slot_reg, free_pos[POS_W-1:0]};
        fifo_we    = 1'b0;
        fifo_waddr = tail_reg;
        fifo_wdata = list_rdata;
        fifo_raddr = head_reg;
        fifo_take  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    rq_next   = req;
                    st_next   = ST_OK;
                    rid_next  = '0;
                    bidx_next = '0;
                    has_next  = 1'b0;
                    slot_next = '0;
                    case (req.req_type)
                        REQ_FORMAT:
                        begin
                            k_next     = '0;
                            acc_next   = '0;
                            hs_next    = 9'(HDR_START);
                            state_next = S_HDR;
                        end
                        REQ_CREATE_AUTO:
                        begin
                            if (highest_reg == ID_MAX)
                            begin
                                st_next    = ST_INVALID_ID;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                rid_next   = highest_reg + 16'sd1;
                                state_next = S_ALLOC;
                            end
                        end
                        REQ_CREATE_ID:
                        begin
                            rid_next   = req.stream_id;
                            state_next = S_FIND;
                        end
                        REQ_DELETE:
                        begin
                            rid_next = req.stream_id;
                            if (req.stream_id[15])
                            begin
                                st_next    = ST_INVALID_ID;
                                state_next = S_DONE;
                            end
                            else if (req.stream_id == 16'sd0)
                            begin
                                st_next    = ST_PROTECTED;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FIND;
                            end
                        end
                        REQ_SET_SIZE, REQ_LOOKUP:
                        begin
                            rid_next   = req.stream_id;
                            state_next = S_FIND;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // header block count: keep adding blocks until the header fits
            S_HDR:
            begin
                if (acc_reg < 23'(hs_reg) + 23'(HDR_TAIL))
                begin
                    if (k_reg == LIST_MAX)
                    begin
                        st_next    = ST_LIST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        k_next   = k_reg + 7'd1;
                        acc_next = acc_reg + 23'(bs_eff);
                    end
                end
                else
                begin
                    hs_next = new_hs;
                    if (23'(new_hs) <= acc_reg)
                    begin
                        if ({4'b0000, k_reg} + {1'b0, rq_reg.count} > 11'(STORE_BLOCKS))
                        begin
                            st_next    = ST_STORE_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            valid_next   = MAX_STREAMS'(1);
                            sw_sel       = '0;
                            sw_id_we     = 1'b1;
                            sw_size_we   = 1'b1;
                            sw_cnt_we    = 1'b1;
                            sw_id        = '0;
                            sw_size      = 23'(new_hs);
                            sw_cnt       = k_reg;
                            head_next    = '0;
                            tail_next    = rq_reg.count[BLK_W-1:0];
                            fcnt_next    = {1'b0, rq_reg.count};
                            total_next   = {4'b0000, k_reg} + {1'b0, rq_reg.count};
                            owned_next   = {4'b0000, k_reg};
                            highest_next = '0;
                            slot_next    = '0;
                            has_next     = 1'b1;
                            fmt_j_next   = '0;
                            state_next   = S_FMT_FILL;
                        end
                    end
                end
            end

            // header blocks go to stream zero, the rest to the free queue
            S_FMT_FILL:
            begin
                if (fmt_j_reg < total_reg)
                begin
                    if (fmt_j_reg < {4'b0000, k_reg})
                    begin
                        list_we    = 1'b1;
                        list_waddr = {SLOT_W'(0), fmt_j_reg[POS_W-1:0]};
                        list_wdata = fmt_j_reg[BLK_W-1:0];
                    end
                    else
                    begin
                        fifo_we    = 1'b1;
                        fifo_waddr = fmt_off[BLK_W-1:0];
                        fifo_wdata = fmt_j_reg[BLK_W-1:0];
                    end
                    fmt_j_next = fmt_j_reg + 11'd1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_FIND:
            begin
                if (hit)
                begin
                    case (rq_reg.req_type)
                        REQ_CREATE_ID:
                        begin
                            st_next    = ST_EXISTS;
                            state_next = S_DONE;
                        end
                        REQ_DELETE:
                        begin
                            fi_next    = '0;
                            fn_next    = cur_cnt;
                            ccnt_next  = cur_cnt;
                            gpend_next = 1'b0;
                            state_next = S_FREE;
                        end
                        REQ_SET_SIZE:
                        begin
                            has_next = 1'b1;
                            k_next   = '0;
                            acc_next = '0;
                            if (rq_reg.new_size > SIZE_LIMIT)
                            begin
                                st_next    = ST_LIST_FULL;
                                state_next = S_DONE;
                            end
                            else if (rq_reg.new_size > cur_size)
                            begin
                                state_next = S_GROW;
                            end
                            else if (rq_reg.new_size < cur_size)
                            begin
                                state_next = S_SHRINK;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        REQ_LOOKUP:
                        begin
                            has_next = 1'b1;
                            if ({1'b0, rq_reg.block_pos} >= cur_cnt)
                            begin
                                st_next    = ST_LIST_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                list_raddr = {slot_reg, rq_reg.block_pos};
                                state_next = S_LOOK;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
                else if (slot_reg == SLOT_LAST)
                begin
                    if (rq_reg.req_type == REQ_CREATE_ID)
                    begin
                        state_next = S_ALLOC;
                    end
                    else
                    begin
                        st_next    = ST_NO_STREAM;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end

            S_ALLOC:
            begin
                if (!free_any)
                begin
                    st_next    = ST_TABLE_FULL;
                    state_next = S_DONE;
                end
                else if (rq_reg.count > 10'(LIST_BLOCKS))
                begin
                    st_next    = ST_LIST_FULL;
                    state_next = S_DONE;
                end
                else if ({2'b00, rq_reg.count} > avail)
                begin
                    st_next    = ST_STORE_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    slot_next            = free_idx;
                    valid_next[free_idx] = 1'b1;
                    sw_sel               = free_idx;
                    sw_id_we             = 1'b1;
                    sw_size_we           = 1'b1;
                    sw_cnt_we            = 1'b1;
                    sw_id                = rid_reg;
                    sw_size              = '0;
                    sw_cnt               = rq_reg.count[6:0];
                    owned_next           = owned_reg + {1'b0, rq_reg.count};
                    if (|valid_reg && (highest_reg > rid_reg))
                    begin
                        highest_next = highest_reg;
                    end
                    else
                    begin
                        highest_next = rid_reg;
                    end
                    has_next   = 1'b1;
                    fj_next    = '0;
                    fend_next  = rq_reg.count[6:0];
                    pend_next  = 1'b0;
                    state_next = S_FILL;
                end
            end

            // take from queue head (or extend the store), write the list entry in the next cycle
            S_FILL:
            begin
                if (pend_reg)
                begin
                    list_we = 1'b1;
                end
                if (fj_reg < fend_reg)
                begin
                    if (fcnt_reg != 11'd0)
                    begin
                        fifo_take      = 1'b1;
                        head_next      = head_reg + BLK_W'(1);
                        fcnt_next      = fcnt_reg - 11'd1;
                        pend_fifo_next = 1'b1;
                    end
                    else
                    begin
                        pend_val_next  = total_reg[BLK_W-1:0];
                        total_next     = total_reg + 11'd1;
                        pend_fifo_next = 1'b0;
                    end
                    pend_next     = 1'b1;
                    pend_pos_next = fj_reg[POS_W-1:0];
                    fj_next       = fj_reg + 7'd1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            // read list entry, push it to queue tail in the next cycle
            S_FREE:
            begin
                if (gpend_reg)
                begin
                    fifo_we   = 1'b1;
                    tail_next = tail_reg + BLK_W'(1);
                    fcnt_next = fcnt_reg + 11'd1;
                end
                if (fi_reg < fn_reg)
                begin
                    fi_next    = fi_reg + 7'd1;
                    gpend_next = 1'b1;
                end
                else
                begin
                    gpend_next = 1'b0;
                    if (!gpend_reg)
                    begin
                        owned_next = owned_reg - {4'b0000, fn_reg};
                        if (rq_reg.req_type == REQ_DELETE)
                        begin
                            valid_next[slot_reg] = 1'b0;
                            slot_next            = '0;
                            any_next             = 1'b0;
                            hmax_next            = '0;
                            state_next           = S_HIGH;
                        end
                        else
                        begin
                            sw_cnt_we  = 1'b1;
                            sw_size_we = 1'b1;
                            sw_cnt     = ccnt_reg - fn_reg;
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_HIGH:
            begin
                if (hi_take)
                begin
                    any_next  = 1'b1;
                    hmax_next = cur_id;
                end
                if (slot_reg == SLOT_LAST)
                begin
                    if (hi_take)
                    begin
                        highest_next = cur_id;
                    end
                    else if (any_reg)
                    begin
                        highest_next = hmax_reg;
                    end
                    else
                    begin
                        highest_next = '0;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end

            // blocks needed: smallest k with k*block_size >= new size
            S_GROW:
            begin
                if (acc_reg < rq_reg.new_size)
                begin
                    if (k_reg == LIST_MAX)
                    begin
                        st_next    = ST_LIST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        k_next   = k_reg + 7'd1;
                        acc_next = acc_reg + 23'(bs_eff);
                    end
                end
                else if (k_reg > cur_cnt)
                begin
                    if ({5'b00000, k_reg - cur_cnt} > avail)
                    begin
                        st_next    = ST_STORE_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        sw_cnt_we  = 1'b1;
                        sw_size_we = 1'b1;
                        owned_next = owned_reg + {4'b0000, k_reg - cur_cnt};
                        fj_next    = cur_cnt;
                        fend_next  = k_reg;
                        pend_next  = 1'b0;
                        state_next = S_FILL;
                    end
                end
                else
                begin
                    sw_size_we = 1'b1;
                    state_next = S_DONE;
                end
            end

            // blocks kept: min(count, new size / block_size + 1)
            S_SHRINK:
            begin
                if ((acc_reg <= rq_reg.new_size) && (k_reg < cur_cnt))
                begin
                    k_next   = k_reg + 7'd1;
                    acc_next = acc_reg + 23'(bs_eff);
                end
                else
                begin
                    fi_next    = '0;
                    fn_next    = cur_cnt - k_reg;
                    ccnt_next  = cur_cnt;
                    gpend_next = 1'b0;
                    state_next = S_FREE;
                end
            end

            S_LOOK:
            begin
                bidx_next  = list_rdata;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status        = st_reg;
                    rsp_next.result_id     = rid_reg;
                    rsp_next.block_index   = bidx_reg;
                    rsp_next.stream_size   = has_reg ? cur_size : '0;
                    rsp_next.stream_blocks = has_reg ? cur_cnt : '0;
                    rsp_next.used_blocks   = owned_reg;
                    rsp_next.total_blocks  = total_reg;
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            bs_reg        <= BS_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            fcnt_reg      <= '0;
            total_reg     <= '0;
            owned_reg     <= '0;
            highest_reg   <= '0;
            pend_reg      <= 1'b0;
            gpend_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            bs_reg        <= bs_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fcnt_reg      <= fcnt_next;
            total_reg     <= total_next;
            owned_reg     <= owned_next;
            highest_reg   <= highest_next;
            pend_reg      <= pend_next;
            gpend_reg     <= gpend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        rq_reg        <= rq_next;
        st_reg        <= st_next;
        rid_reg       <= rid_next;
        bidx_reg      <= bidx_next;
        has_reg       <= has_next;
        k_reg         <= k_next;
        acc_reg       <= acc_next;
        hs_reg        <= hs_next;
        fj_reg        <= fj_next;
        fend_reg      <= fend_next;
        pend_fifo_reg <= pend_fifo_next;
        pend_val_reg  <= pend_val_next;
        pend_pos_reg  <= pend_pos_next;
        fi_reg        <= fi_next;
        fn_reg        <= fn_next;
        ccnt_reg      <= ccnt_next;
        any_reg       <= any_next;
        hmax_reg      <= hmax_next;
        fmt_j_reg     <= fmt_j_next;
        rsp_reg       <= rsp_next;
        if (sw_id_we)
        begin
            slot_id_reg[sw_sel] <= sw_id;
        end
        if (sw_size_we)
        begin
            slot_size_reg[sw_sel] <= sw_size;
        end
        if (sw_cnt_we)
        begin
            slot_cnt_reg[sw_sel] <= sw_cnt;
        end
    end

    sba_ram #(
        .DEPTH (LIST_DEPTH),
        .WIDTH (BLK_W)
    ) u_list_ram (
        .clk   (clk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (list_wdata),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

    sba_ram #(
        .DEPTH (STORE_BLOCKS),
        .WIDTH (BLK_W)
    ) u_free_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (fifo_wdata),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // every block is either owned or queued free between requests
    a_block_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ({1'b0, owned_reg} + {1'b0, fcnt_reg} == {1'b0, total_reg}))
        else $error("owned plus free blocks differ from store total");

    // queue is only popped when it holds something
    a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_take |-> (fcnt_reg != 11'd0))
        else $error("free queue popped while empty");

    // a new response only comes out of the done state
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == S_DONE))
        else $error("response raised outside done state");

endmodule

>>> bench/tb_stream_block_allocator.sv
// Testbench for stream_block_allocator: a directed table, then random requests over
// several block sizes and stall patterns, checked against an in-bench allocator model.
// Depends on sba_pkg and the stream_block_allocator RTL.
module tb_stream_block_allocator;
    import sba_pkg::*;

    localparam int RUN_LIMIT = 2000000;

    typedef struct {
        sba_req_t q;
        bit       typed;
        sba_rsp_t e;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    sba_req_t    req = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    sba_rsp_t    rsp;
    logic        cfg_wen = 1'b0;
    logic [16:0] cfg_wdata = '0;

    // allocator image
    bit          live[STREAM_SLOTS];
    int          sid[STREAM_SLOTS];
    int          ssize[STREAM_SLOTS];
    int          scount[STREAM_SLOTS];
    int          blist[STREAM_SLOTS][LIST_BLOCKS];
    int          free_q[STORE_BLOCKS];
    int          fhead, ftail, fcount, store_total, owned_total, top_id;
    int          blk_bytes;

    sba_rsp_t    rsp_due[$];
    dir_row_t    dir_rows[$];
    int          errors = 0;
    int          hold_left = 0;
    int          tx_pct = 0;
    int          rx_pct = 0;
    int          cycles = 0;

    stream_block_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int take_block();
        int v;
        if (fcount > 0)
        begin
            v = free_q[fhead];
            fhead = (fhead + 1) % STORE_BLOCKS;
            fcount--;
            return v;
        end
        v = store_total;
        store_total++;
        return v;
    endfunction

    function automatic void give_block(int b);
        free_q[ftail] = b;
        ftail = (ftail + 1) % STORE_BLOCKS;
        fcount++;
    endfunction

    function automatic int find_stream(int id);
        for (int s = 0; s < STREAM_SLOTS; s++)
            if (live[s] && sid[s] == id)
                return s;
        return -1;
    endfunction

    function automatic void refresh_top_id();
        bit any;
        int m;
        any = 0;
        m = 0;
        for (int s = 0; s < STREAM_SLOTS; s++)
            if (live[s] && (!any || sid[s] > m))
            begin
                m = sid[s];
                any = 1;
            end
        top_id = m;
    endfunction

    function automatic void grow_list(int s, int from, int n);
        for (int j = from; j < from + n; j++)
            blist[s][j] = take_block();
        scount[s] = from + n;
        owned_total += n;
    endfunction

    function automatic int spare_blocks();
        return fcount + (STORE_BLOCKS - store_total);
    endfunction

    function automatic sba_rsp_t alloc_step(sba_req_t q);
        sba_rsp_t r;
        longint   bs, hs, hb, need, keep;
        int       st, rid, bidx, s, f, c, id, nid;
        bit       ok;
        bs = (blk_bytes == 0) ? 1 : (blk_bytes > 65536) ? 65536 : blk_bytes;
        st = ST_OK;
        rid = 0;
        bidx = 0;
        s = -1;
        id = q.stream_id;
        case (q.req_type)
            REQ_FORMAT:
            begin
                hs = HDR_START;
                hb = 0;
                ok = 1;
                while (hs > hb * bs)
                begin
                    hb = (hs + HDR_TAIL + bs - 1) / bs;
                    hs = HDR_FIXED + 4 * hb;
                    if (hb > LIST_BLOCKS)
                    begin
                        ok = 0;
                        break;
                    end
                end
                if (!ok)
                    st = ST_LIST_FULL;
                else if (hb + q.count > STORE_BLOCKS)
                    st = ST_STORE_FULL;
                else
                begin
                    for (int k = 0; k < STREAM_SLOTS; k++)
                        live[k] = 0;
                    fhead = 0;
                    ftail = 0;
                    fcount = 0;
                    owned_total = hb;
                    store_total = hb + q.count;
                    for (int j = 0; j < hb; j++)
                        blist[0][j] = j;
                    for (int j = hb; j < store_total; j++)
                        give_block(j);
                    live[0] = 1;
                    sid[0] = 0;
                    ssize[0] = hs;
                    scount[0] = hb;
                    top_id = 0;
                    s = 0;
                end
            end
            REQ_CREATE_AUTO, REQ_CREATE_ID:
            begin
                nid = 0;
                if (q.req_type == REQ_CREATE_AUTO)
                begin
                    if (top_id >= ID_MAX)
                        st = ST_INVALID_ID;
                    else
                        nid = top_id + 1;
                end
                else
                begin
                    nid = id;
                    if (find_stream(nid) >= 0)
                        st = ST_EXISTS;
                end
                if (st == ST_OK)
                begin
                    f = -1;
                    for (int k = 0; k < STREAM_SLOTS; k++)
                        if (!live[k] && f < 0)
                            f = k;
                    if (f < 0)
                        st = ST_TABLE_FULL;
                    else if (q.count > LIST_BLOCKS)
                        st = ST_LIST_FULL;
                    else if (q.count > spare_blocks())
                        st = ST_STORE_FULL;
                    else
                    begin
                        live[f] = 1;
                        sid[f] = nid;
                        ssize[f] = 0;
                        grow_list(f, 0, q.count);
                        refresh_top_id();
                        s = f;
                    end
                end
                rid = nid;
            end
            REQ_DELETE:
            begin
                rid = id;
                if (id < 0)
                    st = ST_INVALID_ID;
                else if (id == 0)
                    st = ST_PROTECTED;
                else
                begin
                    f = find_stream(id);
                    if (f < 0)
                        st = ST_NO_STREAM;
                    else
                    begin
                        for (int j = 0; j < scount[f]; j++)
                            give_block(blist[f][j]);
                        owned_total -= scount[f];
                        live[f] = 0;
                        refresh_top_id();
                    end
                end
            end
            REQ_SET_SIZE:
            begin
                rid = id;
                s = find_stream(id);
                if (s < 0)
                    st = ST_NO_STREAM;
                else if (q.new_size > SIZE_LIMIT)
                    st = ST_LIST_FULL;
                else
                begin
                    c = scount[s];
                    if (q.new_size > ssize[s])
                    begin
                        need = (q.new_size + bs - 1) / bs;
                        if (need > c)
                        begin
                            if (need > LIST_BLOCKS)
                                st = ST_LIST_FULL;
                            else if (need - c > spare_blocks())
                                st = ST_STORE_FULL;
                            else
                                grow_list(s, c, need - c);
                        end
                        if (st == ST_OK)
                            ssize[s] = q.new_size;
                    end
                    else if (q.new_size < ssize[s])
                    begin
                        // one block always stays, even at size zero
                        keep = q.new_size / bs + 1;
                        while (c > keep)
                        begin
                            c--;
                            give_block(blist[s][c]);
                            owned_total--;
                        end
                        scount[s] = c;
                        ssize[s] = q.new_size;
                    end
                end
            end
            REQ_LOOKUP:
            begin
                rid = id;
                s = find_stream(id);
                if (s < 0)
                    st = ST_NO_STREAM;
                else if (q.block_pos >= scount[s])
                    st = ST_LIST_FULL;
                else
                    bidx = blist[s][q.block_pos];
            end
            default: ;
        endcase
        r.status        = st[2:0];
        r.result_id     = rid[15:0];
        r.block_index   = bidx[9:0];
        r.stream_size   = (s >= 0) ? ssize[s][22:0] : '0;
        r.stream_blocks = (s >= 0) ? scount[s][6:0] : '0;
        r.used_blocks   = owned_total[10:0];
        r.total_blocks  = store_total[10:0];
        return r;
    endfunction

    function automatic sba_req_t mk_req(logic [2:0] t, int id, int cnt, int nsz, int pos);
        sba_req_t q;
        q.req_type  = t;
        q.stream_id = id[15:0];
        q.count     = cnt[9:0];
        q.new_size  = nsz[22:0];
        q.block_pos = pos[5:0];
        return q;
    endfunction

    function automatic sba_rsp_t mk_rsp(logic [2:0] st, int id, int sz, int nb, int used,
                                        int tot);
        sba_rsp_t r;
        r.status        = st;
        r.result_id     = id[15:0];
        r.block_index   = '0;
        r.stream_size   = sz[22:0];
        r.stream_blocks = nb[6:0];
        r.used_blocks   = used[10:0];
        r.total_blocks  = tot[10:0];
        return r;
    endfunction

    function automatic void add_row(sba_req_t q, bit typed = 0, sba_rsp_t e = '0);
        dir_row_t row;
        row.q = q;
        row.typed = typed;
        row.e = e;
        dir_rows.push_back(row);
    endfunction

    function automatic sba_req_t rand_request();
        sba_req_t q;
        int       pick, s, cands[$], bs;
        q = {$urandom, $urandom};
        bs = (blk_bytes == 0) ? 1 : (blk_bytes > 65536) ? 65536 : blk_bytes;
        pick = $urandom_range(99);
        if (pick < 5)
            return q;   // noise: every field random
        for (int k = 0; k < STREAM_SLOTS; k++)
            if (live[k])
                cands.push_back(k);
        s = (cands.size() > 0) ? cands[$urandom_range(cands.size() - 1)] : -1;
        if (pick < 8)
            q.req_type = REQ_FORMAT;
        else if (pick < 24)
            q.req_type = REQ_CREATE_AUTO;
        else if (pick < 34)
            q.req_type = REQ_CREATE_ID;
        else if (pick < 48)
            q.req_type = REQ_DELETE;
        else if (pick < 74)
            q.req_type = REQ_SET_SIZE;
        else if (pick < 98)
            q.req_type = REQ_LOOKUP;
        if (s >= 0 && $urandom_range(99) < 80)
            q.stream_id = sid[s][15:0];
        else if ($urandom_range(1))
            q.stream_id = $urandom_range(40);
        pick = $urandom_range(99);
        if (q.req_type == REQ_FORMAT)
            q.count = (pick < 80) ? $urandom_range(100) : $urandom_range(1023);
        else if (pick < 70)
            q.count = $urandom_range(6);
        else if (pick < 95)
            q.count = $urandom_range(65);
        pick = $urandom_range(99);
        if (pick < 85)
            q.new_size = ($urandom_range(66) * bs + $urandom_range(2 * bs) - bs) & 23'h7FFFFF;
        else if (pick < 90)
            q.new_size = SIZE_LIMIT;
        if (s >= 0 && $urandom_range(99) < 80)
            q.block_pos = $urandom_range(scount[s]);
        return q;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // one item out, predicted when accepted
    task automatic send(sba_req_t q, bit typed = 0, sba_rsp_t e = '0);
        sba_rsp_t p;
        int       gap;
        gap = 0;
        while ($urandom_range(99) < tx_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= q;
        do
            @(posedge clk);
        while (req_stall);
        p = alloc_step(q);
        rsp_due.push_back(typed ? e : p);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (rsp_due.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_block_size(int v);
        cfg_wen <= 1'b1;
        cfg_wdata <= v[16:0];
        @(posedge clk);
        cfg_wen <= 1'b0;
        blk_bytes = v & 32'h1FFFF;
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else
            rsp_stall <= ($urandom_range(99) < rx_pct);
    end

    always @(posedge clk)
    begin
        sba_rsp_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rsp_due.size() == 0)
            begin
                $display("unexpected response at cycle %0d", cycles);
                errors++;
            end
            else
            begin
                e = rsp_due.pop_front();
                if (rsp.status != e.status)
                    flag_mismatch("status", rsp.status, e.status);
                if (rsp.result_id != e.result_id)
                    flag_mismatch("result_id", rsp.result_id, e.result_id);
                if (rsp.block_index != e.block_index)
                    flag_mismatch("block_index", rsp.block_index, e.block_index);
                if (rsp.stream_size != e.stream_size)
                    flag_mismatch("stream_size", rsp.stream_size, e.stream_size);
                if (rsp.stream_blocks != e.stream_blocks)
                    flag_mismatch("stream_blocks", rsp.stream_blocks, e.stream_blocks);
                if (rsp.used_blocks != e.used_blocks)
                    flag_mismatch("used_blocks", rsp.used_blocks, e.used_blocks);
                if (rsp.total_blocks != e.total_blocks)
                    flag_mismatch("total_blocks", rsp.total_blocks, e.total_blocks);
            end
        end
    end

    initial
    begin
        repeat (RUN_LIMIT) @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int sizes[8];
        for (int k = 0; k < STREAM_SLOTS; k++)
            live[k] = 0;
        fhead = 0;
        ftail = 0;
        fcount = 0;
        store_total = 0;
        owned_total = 0;
        top_id = 0;
        blk_bytes = BS_RESET;

        // directed table at the reset block size
        add_row(mk_req(REQ_LOOKUP, 0, 0, 0, 0), 1, mk_rsp(ST_NO_STREAM, 0, 0, 0, 0, 0));
        add_row(mk_req(REQ_DELETE, -1, 0, 0, 0), 1, mk_rsp(ST_INVALID_ID, -1, 0, 0, 0, 0));
        add_row(mk_req(REQ_DELETE, 0, 0, 0, 0), 1, mk_rsp(ST_PROTECTED, 0, 0, 0, 0, 0));
        add_row(mk_req(REQ_DELETE, 5, 0, 0, 0), 1, mk_rsp(ST_NO_STREAM, 5, 0, 0, 0, 0));
        add_row(mk_req(REQ_CREATE_AUTO, 0, 3, 0, 0));            // before format
        add_row(mk_req(REQ_CREATE_ID, -32768, 64, 0, 0));
        add_row(mk_req(REQ_LOOKUP, -32768, 0, 0, 63));
        add_row(mk_req(REQ_FORMAT, 0, 0, 0, 0), 1, mk_rsp(ST_OK, 0, 26, 1, 1, 1));
        add_row(mk_req(REQ_FORMAT, 0, 1023, 0, 0));
        add_row(mk_req(REQ_CREATE_ID, 32767, 0, 0, 0));
        add_row(mk_req(REQ_CREATE_AUTO, 0, 0, 0, 0), 1,
                mk_rsp(ST_INVALID_ID, 0, 0, 0, 1, 1024));
        add_row(mk_req(REQ_CREATE_ID, 32767, 0, 0, 0), 1,
                mk_rsp(ST_EXISTS, 32767, 0, 0, 1, 1024));
        add_row(mk_req(REQ_CREATE_ID, 7, 65, 0, 0));
        add_row(mk_req(REQ_CREATE_ID, 7, 64, 0, 0));
        add_row(mk_req(REQ_SET_SIZE, 7, 0, 23'h7FFFFF, 0));
        add_row(mk_req(REQ_SET_SIZE, 7, 0, SIZE_LIMIT, 0));
        add_row(mk_req(REQ_SET_SIZE, 7, 0, 32768, 0));
        add_row(mk_req(REQ_SET_SIZE, 7, 0, 0, 0));
        add_row(mk_req(REQ_LOOKUP, 7, 0, 0, 1));
        add_row(mk_req(REQ_LOOKUP, 7, 0, 0, 0));
        add_row(mk_req(3'd6, 7, 0, 0, 0));
        add_row(mk_req(3'd7, -1, 1023, 23'h7FFFFF, 63));
        add_row(mk_req(REQ_DELETE, 7, 0, 0, 0));
        add_row(mk_req(REQ_SET_SIZE, 9, 0, 100, 0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send(dir_rows[i].q, dir_rows[i].typed, dir_rows[i].e);
        drain();

        sizes = '{BS_RESET, 1, 8, BS_MAX, 17'h1FFFF, 0, 64, 4096};
        for (int ph = 0; ph < 8; ph++)
        begin
            set_block_size(sizes[ph]);
            case (ph % 4)
                0: begin tx_pct = 0;  rx_pct = 0;  end
                1: begin tx_pct = 71; rx_pct = 0;  end
                2: begin tx_pct = 0;  rx_pct = 71; end
                default: begin tx_pct = 11; rx_pct = 11; end
            endcase
            send(mk_req(REQ_FORMAT, 0, $urandom_range(200), 0, 0));
            for (int n = 0; n < 225; n++)
            begin
                if (ph == 0 && n == 100)
                begin
                    // long receiver hold-off while requests keep coming
                    hold_left = 600;
                    for (int k = 0; k < 12; k++)
                        send(rand_request());
                end
                if (ph == 3 && n == 100)
                    drain();
                send(rand_request());
            end
            drain();
        end

        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
